// ----- sv/stable_priority_queue_top_assert.svh -----
// assertion macros used by the checker file spq_checker.sv
`ifndef STABLE_PRIORITY_QUEUE_TOP_ASSERT_SVH
`define STABLE_PRIORITY_QUEUE_TOP_ASSERT_SVH

// checked on every clock edge outside reset
`define SPQ_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// checked on every clock edge, reset included
`define SPQ_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- sv/spq_pkg.sv -----
// package with the types and constants of the stable priority queue
package spq_pkg;

  localparam int CAPACITY = 16;
  localparam int CNT_W    = $clog2(CAPACITY + 1);

  typedef enum logic [1:0] {
    FUNC_INSERT = 2'd0,
    FUNC_POP    = 2'd1,
    FUNC_LIST   = 2'd2,
    FUNC_NONE   = 2'd3
  } func_e;

  typedef enum logic [2:0] {
    KIND_INSERTED = 3'd0,
    KIND_POPPED   = 3'd1,
    KIND_LISTED   = 3'd2,
    KIND_EMPTY    = 3'd3,
    KIND_FULL     = 3'd4
  } kind_e;

  typedef enum logic [1:0] {
    CMD_HOLD,
    CMD_INSERT,
    CMD_POP,
    CMD_ROTATE
  } cmd_e;

  typedef enum logic {
    ST_IDLE,
    ST_LIST
  } state_e;

  typedef struct packed {
    logic [1:0]  func;
    logic [15:0] entry_id;
    logic [3:0]  priority_req;
  } req_t;

  typedef struct packed {
    logic [2:0]  kind;
    logic [15:0] out_id;
    logic [3:0]  out_priority;
    logic        last;
  } rsp_t;

  typedef struct packed {
    logic [15:0] id;
    logic [3:0]  prio;
  } slot_t;

  typedef struct packed {
    cmd_e  cmd;
    slot_t new_slot;
  } cell_ctrl_t;

endpackage

// ----- sv/stable_priority_queue_top.sv -----
// Stable priority queue: a chain of CAPACITY slot cells kept sorted, highest
// priority at slot 0, equal priorities in arrival order. Insert and pop each
// give one transaction; the whole chain compares against the new priority and
// shifts in the cycle that takes the request, so a new request can be taken
// every cycle while the response side keeps up. A list request turns the
// occupied cells as a ring, one entry per cycle while the response side keeps
// up, starting after the cycle that takes the request (an empty queue gets a
// single empty report instead); no request is taken until the last listed
// entry has been handed to the response register.
// An insert into a full queue is dropped and answered with kind full.
module stable_priority_queue_top (
  input  logic          clk,
  input  logic          rst,
  input  logic          req_valid,
  output logic          req_stall,
  input  spq_pkg::req_t req,
  output logic          rsp_valid,
  input  logic          rsp_stall,
  output spq_pkg::rsp_t rsp
);
  import spq_pkg::*;

  state_e           state, state_next;
  logic [CNT_W-1:0] count, count_next;
  logic [CNT_W-1:0] remain, remain_next;
  cell_ctrl_t       ctrl;
  logic             load;
  rsp_t             rsp_next;
  logic             can_load;
  logic             accept;

  slot_t cell_q  [CAPACITY];
  slot_t lslot   [CAPACITY];
  slot_t rslot   [CAPACITY];
  logic  cell_ge [CAPACITY];
  logic  lge     [CAPACITY];
  logic  occ     [CAPACITY];
  logic  tail    [CAPACITY];

  assign can_load  = !rsp_valid || !rsp_stall;
  assign req_stall = (state != ST_IDLE) || !can_load;
  assign accept    = req_valid && !req_stall;

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    assign occ[i]  = CNT_W'(i) < count;
    assign tail[i] = count == CNT_W'(i + 1);
    if (i == 0) begin : g_head
      assign lge[i]   = 1'b1;
      assign lslot[i] = ctrl.new_slot;
    end else begin : g_body
      assign lge[i]   = cell_ge[i-1];
      assign lslot[i] = cell_q[i-1];
    end
    if (i == CAPACITY - 1) begin : g_end
      assign rslot[i] = cell_q[i];
    end else begin : g_mid
      assign rslot[i] = cell_q[i+1];
    end

    spq_cell u_cell (
      .clk        (clk),
      .ctrl       (ctrl),
      .occupied   (occ[i]),
      .at_tail    (tail[i]),
      .left_ge    (lge[i]),
      .left_slot  (lslot[i]),
      .right_slot (rslot[i]),
      .head_slot  (cell_q[0]),
      .slot       (cell_q[i]),
      .ge         (cell_ge[i])
    );
  end

  always_comb begin
    state_next    = state;
    count_next    = count;
    remain_next   = remain;
    ctrl.cmd      = CMD_HOLD;
    ctrl.new_slot = '{id: req.entry_id, prio: req.priority_req};
    load          = 1'b0;
    rsp_next      = '{kind: KIND_EMPTY, out_id: '0, out_priority: '0, last: 1'b1};
    case (state)
      ST_IDLE: begin
        if (accept) begin
          case (req.func)
            FUNC_INSERT: begin
              load = 1'b1;
              rsp_next.out_id       = req.entry_id;
              rsp_next.out_priority = req.priority_req;
              if (count == CNT_W'(CAPACITY)) begin
                rsp_next.kind = KIND_FULL;
              end else begin
                rsp_next.kind = KIND_INSERTED;
                ctrl.cmd      = CMD_INSERT;
                count_next    = count + CNT_W'(1);
              end
            end
            FUNC_POP: begin
              load = 1'b1;
              if (count != '0) begin
                rsp_next.kind         = KIND_POPPED;
                rsp_next.out_id       = cell_q[0].id;
                rsp_next.out_priority = cell_q[0].prio;
                ctrl.cmd              = CMD_POP;
                count_next            = count - CNT_W'(1);
              end
            end
            FUNC_LIST: begin
              if (count == '0) begin
                load = 1'b1;
              end else begin
                state_next  = ST_LIST;
                remain_next = count;
              end
            end
            default: begin
              load = 1'b0;
            end
          endcase
        end
      end
      ST_LIST: begin
        if (can_load) begin
          load                  = 1'b1;
          ctrl.cmd              = CMD_ROTATE;
          rsp_next.kind         = KIND_LISTED;
          rsp_next.out_id       = cell_q[0].id;
          rsp_next.out_priority = cell_q[0].prio;
          rsp_next.last         = remain == CNT_W'(1);
          remain_next           = remain - CNT_W'(1);
          if (remain == CNT_W'(1)) begin
            state_next = ST_IDLE;
          end
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      count     <= '0;
      remain    <= '0;
      rsp_valid <= 1'b0;
    end else begin
      state  <= state_next;
      count  <= count_next;
      remain <= remain_next;
      if (load) begin
        rsp_valid <= 1'b1;
      end else if (!rsp_stall) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      rsp <= rsp_next;
    end
  end

endmodule

// ----- sv/spq_cell.sv -----
// one slot of the sorted chain: holds, takes the new entry or a neighbor's entry
module spq_cell (
  input  logic               clk,
  input  spq_pkg::cell_ctrl_t ctrl,
  input  logic               occupied,
  input  logic               at_tail,
  input  logic               left_ge,
  input  spq_pkg::slot_t     left_slot,
  input  spq_pkg::slot_t     right_slot,
  input  spq_pkg::slot_t     head_slot,
  output spq_pkg::slot_t     slot,
  output logic               ge
);
  import spq_pkg::*;

  slot_t slot_next;

  // entry stays ahead of an insert of equal or lower priority
  assign ge = occupied && (slot.prio >= ctrl.new_slot.prio);

  always_comb begin
    slot_next = slot;
    case (ctrl.cmd)
      CMD_INSERT: begin
        if (!ge) begin
          slot_next = left_ge ? ctrl.new_slot : left_slot;
        end
      end
      CMD_POP: begin
        slot_next = right_slot;
      end
      CMD_ROTATE: begin
        // occupied slots turn as a ring so the list ends where it began
        if (occupied) begin
          slot_next = at_tail ? head_slot : right_slot;
        end
      end
      default: begin
        slot_next = slot;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    slot <= slot_next;
  end

endmodule

// ----- sv/spq_checker.sv -----
// port-level checks of the stable priority queue, bound to the top level
`include "stable_priority_queue_top_assert.svh"

module spq_checker (
  input logic          clk,
  input logic          rst,
  input logic          req_valid,
  input logic          req_stall,
  input spq_pkg::req_t req,
  input logic          rsp_valid,
  input logic          rsp_stall,
  input spq_pkg::rsp_t rsp
);
  import spq_pkg::*;

  // a stalled response transaction holds
  `SPQ_ASSERT(a_rsp_hold, rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp), "rsp changed under stall")

  // nothing is offered right after reset
  `SPQ_ASSERT_ALWAYS(a_rst_quiet, rst |=> !rsp_valid, "rsp_valid after reset")

  // insert and pop answer in the next cycle
  `SPQ_ASSERT(a_one_cycle, req_valid && !req_stall && (req.func == FUNC_INSERT || req.func == FUNC_POP) |=> rsp_valid, "insert or pop gave no response")

  // an empty report carries a zero entry and closes its request
  `SPQ_ASSERT(a_empty_form, rsp_valid && rsp.kind == KIND_EMPTY |-> rsp.out_id == '0 && rsp.out_priority == '0 && rsp.last, "malformed empty report")

endmodule

bind stable_priority_queue_top spq_checker u_spq_checker (.*);
